// File: hw/rtl/spbr_pkg.sv
// Types, constants and lookup tables shared by the protection bank and random blocks.
package spbr_pkg;

	// Field widths of one bus access and one result.
	localparam int unsigned ACTION_W  = 2;
	localparam int unsigned ADDR_W    = 24;
	localparam int unsigned DATA_W    = 16;
	localparam int unsigned OFFSET_W  = 24;
	localparam int unsigned VARIANT_W = 3;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 16;

	// Bank table geometry.
	localparam int unsigned BANK_ENTRIES = 64;
	localparam int unsigned BANK_IDX_W   = $clog2(BANK_ENTRIES);
	localparam int unsigned BIT_SEL_W    = $clog2(DATA_W);
	localparam int unsigned NUM_SLOTS    = 2 ** VARIANT_W;

	// Access kinds.
	localparam logic [ACTION_W-1:0] ACT_READ16  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_WRITE16 = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_WRITE8  = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_NONE    = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_VARIANT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEED    = 1'd1;

	// Variant codes that select a table and port set.
	localparam logic [VARIANT_W-1:0] VAR_TBL0 = 3'd0;
	localparam logic [VARIANT_W-1:0] VAR_TBL1 = 3'd1;
	localparam logic [VARIANT_W-1:0] VAR_TBL2 = 3'd2;
	localparam logic [VARIANT_W-1:0] VAR_TBL3 = 3'd3;
	localparam logic [VARIANT_W-1:0] VAR_TBL4 = 3'd4;

	// Fixed identification word and reset values.
	localparam logic [ADDR_W-1:0]  ID_ADDR    = 24'h2fe446;
	localparam logic [DATA_W-1:0]  ID_WORD    = 16'h9a37;
	localparam logic [DATA_W-1:0]  SEED_RESET = 16'd9029;
	localparam logic [VARIANT_W-1:0] VARIANT_RESET = VAR_TBL0;

	// Port sets per variant code; codes without a table have no ports.
	localparam logic [ADDR_W-1:0] GEN_A_ADDR [NUM_SLOTS] = '{
		24'h2ffff8, 24'h2fffcc, 24'h2fffcc, 24'h000000,
		24'h2fffd8, 24'h000000, 24'h000000, 24'h000000};
	localparam logic [ADDR_W-1:0] GEN_B_ADDR [NUM_SLOTS] = '{
		24'h2ffffa, 24'h2ffff0, 24'h2ffff0, 24'h000000,
		24'h2fffda, 24'h000000, 24'h000000, 24'h000000};
	localparam logic [ADDR_W-1:0] BANK_ADDR [NUM_SLOTS] = '{
		24'h2ffff0, 24'h2fffc0, 24'h2fffc0, 24'h2fffe4,
		24'h2fffec, 24'h000000, 24'h000000, 24'h000000};
	localparam logic HAS_GEN  [NUM_SLOTS] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
	localparam logic HAS_BANK [NUM_SLOTS] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0};

	// Data bit that feeds each bank index bit, first entry is index bit 0.
	localparam logic [BIT_SEL_W-1:0] SCRAMBLE [NUM_SLOTS][BANK_IDX_W] = '{
		'{4'd14, 4'd6,  4'd8,  4'd10, 4'd12, 4'd5},
		'{4'd5,  4'd9,  4'd7,  4'd6,  4'd14, 4'd12},
		'{4'd4,  4'd8,  4'd14, 4'd2,  4'd11, 4'd13},
		'{4'd14, 4'd12, 4'd15, 4'd6,  4'd3,  4'd9},
		'{4'd15, 4'd14, 4'd7,  4'd3,  4'd10, 4'd5},
		'{4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0},
		'{4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0},
		'{4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0}};

	// Bank offset tables; entries past the listed ones are zero.
	localparam logic [OFFSET_W-1:0] OFS_TBL0 [BANK_ENTRIES] = '{
		24'h000000, 24'h100000, 24'h200000, 24'h300000, 24'h3cc000, 24'h4cc000, 24'h3f2000, 24'h4f2000,
		24'h407800, 24'h507800, 24'h40d000, 24'h50d000, 24'h417800, 24'h517800, 24'h420800, 24'h520800,
		24'h424800, 24'h524800, 24'h429000, 24'h529000, 24'h42e800, 24'h52e800, 24'h431800, 24'h531800,
		24'h54d000, 24'h551000, 24'h567000, 24'h592800, 24'h588800, 24'h581800, 24'h599800, 24'h594800,
		24'h598000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
		24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
		24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
		24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000};
	localparam logic [OFFSET_W-1:0] OFS_TBL1 [BANK_ENTRIES] = '{
		24'h000000, 24'h100000, 24'h200000, 24'h300000, 24'h280000, 24'h380000, 24'h2d0000, 24'h3d0000,
		24'h2f0000, 24'h3f0000, 24'h400000, 24'h500000, 24'h420000, 24'h520000, 24'h440000, 24'h540000,
		24'h498000, 24'h598000, 24'h4a0000, 24'h5a0000, 24'h4a8000, 24'h5a8000, 24'h4b0000, 24'h5b0000,
		24'h4b8000, 24'h5b8000, 24'h4c0000, 24'h5c0000, 24'h4c8000, 24'h5c8000, 24'h4d0000, 24'h5d0000,
		24'h458000, 24'h558000, 24'h460000, 24'h560000, 24'h468000, 24'h568000, 24'h470000, 24'h570000,
		24'h478000, 24'h578000, 24'h480000, 24'h580000, 24'h488000, 24'h588000, 24'h490000, 24'h590000,
		24'h5d0000, 24'h5d8000, 24'h5e0000, 24'h5e8000, 24'h5f0000, 24'h5f8000, 24'h600000, 24'h000000,
		24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000};
	localparam logic [OFFSET_W-1:0] OFS_TBL2 [BANK_ENTRIES] = '{
		24'h000000, 24'h100000, 24'h200000, 24'h300000, 24'h280000, 24'h380000, 24'h2d0000, 24'h3d0000,
		24'h2c8000, 24'h3c8000, 24'h400000, 24'h500000, 24'h420000, 24'h520000, 24'h440000, 24'h540000,
		24'h598000, 24'h698000, 24'h5a0000, 24'h6a0000, 24'h5a8000, 24'h6a8000, 24'h5b0000, 24'h6b0000,
		24'h5b8000, 24'h6b8000, 24'h5c0000, 24'h6c0000, 24'h5c8000, 24'h6c8000, 24'h5d0000, 24'h6d0000,
		24'h458000, 24'h558000, 24'h460000, 24'h560000, 24'h468000, 24'h568000, 24'h470000, 24'h570000,
		24'h478000, 24'h578000, 24'h480000, 24'h580000, 24'h488000, 24'h588000, 24'h490000, 24'h590000,
		24'h5d8000, 24'h6d8000, 24'h5e0000, 24'h6e0000, 24'h5e8000, 24'h6e8000, 24'h6e8000, 24'h000000,
		24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000};
	localparam logic [OFFSET_W-1:0] OFS_TBL3 [BANK_ENTRIES] = '{
		24'h000000, 24'h020000, 24'h040000, 24'h060000, 24'h070000, 24'h090000, 24'h0b0000, 24'h0d0000,
		24'h0e0000, 24'h0f0000, 24'h120000, 24'h130000, 24'h140000, 24'h150000, 24'h180000, 24'h190000,
		24'h1a0000, 24'h1b0000, 24'h1e0000, 24'h1f0000, 24'h200000, 24'h210000, 24'h240000, 24'h250000,
		24'h260000, 24'h270000, 24'h2a0000, 24'h2b0000, 24'h2c0000, 24'h2d0000, 24'h300000, 24'h310000,
		24'h320000, 24'h330000, 24'h360000, 24'h370000, 24'h380000, 24'h390000, 24'h3c0000, 24'h3d0000,
		24'h400000, 24'h410000, 24'h440000, 24'h450000, 24'h460000, 24'h470000, 24'h4a0000, 24'h4b0000,
		24'h4c0000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
		24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000};
	localparam logic [OFFSET_W-1:0] OFS_TBL4 [BANK_ENTRIES] = '{
		24'h000000, 24'h100000, 24'h200000, 24'h300000, 24'h3f7800, 24'h4f7800, 24'h3ff800, 24'h4ff800,
		24'h407800, 24'h507800, 24'h40f800, 24'h50f800, 24'h416800, 24'h516800, 24'h41d800, 24'h51d800,
		24'h424000, 24'h524000, 24'h523800, 24'h623800, 24'h526000, 24'h626000, 24'h528000, 24'h628000,
		24'h52a000, 24'h62a000, 24'h52b800, 24'h62b800, 24'h52d000, 24'h62d000, 24'h52e800, 24'h62e800,
		24'h618000, 24'h619000, 24'h61a000, 24'h61a800, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
		24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
		24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
		24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000};

	// One result item.
	typedef struct packed {
		logic [DATA_W-1:0]   read_data;
		logic                read_answered;
		logic                bank_valid;
		logic [OFFSET_W-1:0] bank_offset;
		logic                write_passed;
	} spbr_result_t;

	// Looks up the bank offset of one variant; codes without a table give zero.
	function automatic logic [OFFSET_W-1:0] bank_offset_lookup(
		input logic [VARIANT_W-1:0]  variant,
		input logic [BANK_IDX_W-1:0] idx
	);
		logic [OFFSET_W-1:0] ofs;
		case (variant)
			VAR_TBL0: ofs = OFS_TBL0[idx];
			VAR_TBL1: ofs = OFS_TBL1[idx];
			VAR_TBL2: ofs = OFS_TBL2[idx];
			VAR_TBL3: ofs = OFS_TBL3[idx];
			VAR_TBL4: ofs = OFS_TBL4[idx];
			default:  ofs = '0;
		endcase
		return ofs;
	endfunction

endpackage

// File: hw/rtl/spbr_if.sv
// Valid/ready channel interfaces for bus accesses and result items.
interface spbr_access_if;
	import spbr_pkg::*;

	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [ADDR_W-1:0]   address;
	logic [DATA_W-1:0]   data;

	modport source (output valid, action, address, data, input ready);
	modport sink (input valid, action, address, data, output ready);
endinterface

interface spbr_result_if;
	import spbr_pkg::*;

	logic                valid;
	logic                ready;
	logic [DATA_W-1:0]   read_data;
	logic                read_answered;
	logic                bank_valid;
	logic [OFFSET_W-1:0] bank_offset;
	logic                write_passed;

	modport source (output valid, read_data, read_answered, bank_valid, bank_offset,
		write_passed, input ready);
	modport sink (input valid, read_data, read_answered, bank_valid, bank_offset,
		write_passed, output ready);
endinterface

// File: hw/rtl/spbr_lfsr.sv
// 16-bit random generator register with seed load and single step.
module spbr_lfsr (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  logic [spbr_pkg::DATA_W-1:0] seed,
	input  logic                      step,
	output logic [spbr_pkg::DATA_W-1:0] state
);
	import spbr_pkg::*;

	logic [DATA_W-1:0] shift_q;
	logic              feedback;

	// Feedback taps at bits 2, 3, 5, 6, 7, 11, 12 and 15.
	assign feedback = shift_q[2] ^ shift_q[3] ^ shift_q[5] ^ shift_q[6] ^
		shift_q[7] ^ shift_q[11] ^ shift_q[12] ^ shift_q[15];

	// A seed write reloads the register; a generator read shifts it left by one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= SEED_RESET;
		end else if (load) begin
			shift_q <= seed;
		end else if (step) begin
			shift_q <= {shift_q[DATA_W-2:0], feedback};
		end
	end

	assign state = shift_q;
endmodule

// File: hw/rtl/spbr_decode.sv
// Decodes one registered bus access into its result and a generator step request.
module spbr_decode (
	input  logic [spbr_pkg::VARIANT_W-1:0] variant,
	input  logic [spbr_pkg::ACTION_W-1:0]  action,
	input  logic [spbr_pkg::ADDR_W-1:0]    address,
	input  logic [spbr_pkg::DATA_W-1:0]    data,
	input  logic [spbr_pkg::DATA_W-1:0]    random_value,
	output spbr_pkg::spbr_result_t         result,
	output logic                           gen_step
);
	import spbr_pkg::*;

	logic [ADDR_W-1:0]     waddr;
	logic [DATA_W-1:0]     wdata;
	logic [BANK_IDX_W-1:0] bank_idx;
	logic                  gen_hit;
	logic                  bank_hit;

	// Byte writes place the byte by address parity and align the address.
	always_comb begin
		if (action == ACT_WRITE8) begin
			waddr = {address[ADDR_W-1:1], 1'b0};
			if (address[0]) begin
				wdata = {8'h00, data[7:0]};
			end else begin
				wdata = {data[7:0], 8'h00};
			end
		end else begin
			waddr = address;
			wdata = data;
		end
	end

	// Gather the scrambled data bits into the bank index.
	always_comb begin
		for (int i = 0; i < BANK_IDX_W; i++) begin
			bank_idx[i] = wdata[SCRAMBLE[variant][i]];
		end
	end

	assign gen_hit = HAS_GEN[variant] &&
		(address == GEN_A_ADDR[variant] || address == GEN_B_ADDR[variant]);
	assign bank_hit = HAS_BANK[variant] && (waddr == BANK_ADDR[variant]);

	// The fixed word wins over the generator ports; other reads pass through.
	always_comb begin
		result   = '0;
		gen_step = 1'b0;
		case (action)
			ACT_READ16: begin
				if (address == ID_ADDR) begin
					result.read_data     = ID_WORD;
					result.read_answered = 1'b1;
				end else if (gen_hit) begin
					result.read_data     = random_value;
					result.read_answered = 1'b1;
					gen_step             = 1'b1;
				end
			end
			ACT_WRITE16, ACT_WRITE8: begin
				if (bank_hit) begin
					result.bank_valid  = 1'b1;
					result.bank_offset = bank_offset_lookup(variant, bank_idx);
				end else begin
					result.write_passed = 1'b1;
				end
			end
			default: begin
				result = '0;
			end
		endcase
	end
endmodule

// File: hw/rtl/sma_protection_bank_and_random_core.sv
// Top level of the cartridge protection block: input register, decode, result register.
// Each bus access transfers into an input register, is decoded there against the
// selected variant's ports and tables, and moves on into the result register when
// that register is empty or being emptied, and from there its result can
// transfer out; one access is taken every cycle while the result side keeps
// up, and a stalled result holds the input side only once the input register is
// also full. A 16-bit read of the fixed ID address answers 0x9a37, a read of a
// generator port answers the 16-bit generator value and then steps it, and a write
// to the bank port yields a bank offset from the variant's table. Writing the seed
// register reloads the generator at once; configuration is meant to change only
// while no access is in flight.
module sma_protection_bank_and_random_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [spbr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [spbr_pkg::CFG_DATA_W-1:0] cfg_wdata,
	spbr_access_if.sink                     access,
	spbr_result_if.source                   result
);
	import spbr_pkg::*;

	logic [VARIANT_W-1:0] variant_q;
	logic                 valid_s1;
	logic [ACTION_W-1:0]  action_s1;
	logic [ADDR_W-1:0]    address_s1;
	logic [DATA_W-1:0]    data_s1;
	logic                 valid_s2;
	spbr_result_t         result_s2;
	spbr_result_t         dec_result;
	logic                 dec_step;
	logic                 gen_step;
	logic                 seed_load;
	logic [DATA_W-1:0]    random_value;
	logic                 out_adv;
	logic                 s1_adv;

	// Configuration writes.
	assign seed_load = cfg_we && (cfg_index == REG_SEED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= VARIANT_RESET;
		end else if (cfg_we && (cfg_index == REG_VARIANT)) begin
			variant_q <= cfg_wdata[VARIANT_W-1:0];
		end
	end

	// Pipeline flow: the result register frees when empty or taken.
	assign out_adv      = !valid_s2 || result.ready;
	assign s1_adv       = valid_s1 && out_adv;
	assign access.ready = !valid_s1 || out_adv;
	assign gen_step     = s1_adv && dec_step;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (access.ready) begin
			valid_s1 <= access.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (access.valid && access.ready) begin
			action_s1  <= access.action;
			address_s1 <= access.address;
			data_s1    <= access.data;
		end
	end

	spbr_lfsr u_lfsr (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (seed_load),
		.seed   (cfg_wdata[DATA_W-1:0]),
		.step   (gen_step),
		.state  (random_value)
	);

	spbr_decode u_decode (
		.variant      (variant_q),
		.action       (action_s1),
		.address      (address_s1),
		.data         (data_s1),
		.random_value (random_value),
		.result       (dec_result),
		.gen_step     (dec_step)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			result_s2 <= dec_result;
		end
	end

	assign result.valid         = valid_s2;
	assign result.read_data     = result_s2.read_data;
	assign result.read_answered = result_s2.read_answered;
	assign result.bank_valid    = result_s2.bank_valid;
	assign result.bank_offset   = result_s2.bank_offset;
	assign result.write_passed  = result_s2.write_passed;

	// A result is either a read answer, a bank switch or a passed write, never two.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(result_s2.read_answered && (result_s2.bank_valid ||
			result_s2.write_passed)))
		else $error("read answer mixed with write outcome");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(result_s2.bank_valid && result_s2.write_passed))
		else $error("bank switch and passed write together");

	// The generator moves only on a delivered generator read or a seed write.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!gen_step && !seed_load) |=> $stable(random_value))
		else $error("generator changed without a step or seed write");

	// An item waiting in the input register is not lost while the output stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_adv) |=> (valid_s1 && $stable(address_s1)))
		else $error("input register item dropped during stall");
endmodule

// File: tb/sv/sma_protection_bank_and_random_core_tb.sv
// Self-checking testbench for the cartridge protection bank and random core.
module sma_protection_bank_and_random_core_tb;
	import spbr_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int MAX_REPORTS     = 50;

	// Address map and tables of the protection device, one entry per variant code 0..4.
	localparam logic [ADDR_W-1:0] FIXED_ID_ADDR = 24'h2fe446;
	localparam logic [DATA_W-1:0] FIXED_ID_WORD = 16'h9a37;
	localparam logic [DATA_W-1:0] SEED_AT_RESET = 16'd9029;
	localparam logic [DATA_W-1:0] LFSR_TAPS     = 16'h98ec;

	localparam logic [ADDR_W-1:0] RNG_PORT_A [5] = '{
		24'h2ffff8, 24'h2fffcc, 24'h2fffcc, 24'h000000, 24'h2fffd8};
	localparam logic [ADDR_W-1:0] RNG_PORT_B [5] = '{
		24'h2ffffa, 24'h2ffff0, 24'h2ffff0, 24'h000000, 24'h2fffda};
	localparam logic [ADDR_W-1:0] BANK_PORT [5] = '{
		24'h2ffff0, 24'h2fffc0, 24'h2fffc0, 24'h2fffe4, 24'h2fffec};
	localparam int BANK_BIT_SEL [5][6] = '{
		'{14, 6, 8, 10, 12, 5},
		'{5, 9, 7, 6, 14, 12},
		'{4, 8, 14, 2, 11, 13},
		'{14, 12, 15, 6, 3, 9},
		'{15, 14, 7, 3, 10, 5}};

	// Only the listed entries; any index past the end selects offset zero.
	localparam logic [OFFSET_W-1:0] BASE_V0 [33] = '{
		24'h000000, 24'h100000, 24'h200000, 24'h300000, 24'h3cc000, 24'h4cc000, 24'h3f2000,
		24'h4f2000, 24'h407800, 24'h507800, 24'h40d000, 24'h50d000, 24'h417800, 24'h517800,
		24'h420800, 24'h520800, 24'h424800, 24'h524800, 24'h429000, 24'h529000, 24'h42e800,
		24'h52e800, 24'h431800, 24'h531800, 24'h54d000, 24'h551000, 24'h567000, 24'h592800,
		24'h588800, 24'h581800, 24'h599800, 24'h594800, 24'h598000};
	localparam logic [OFFSET_W-1:0] BASE_V1 [55] = '{
		24'h000000, 24'h100000, 24'h200000, 24'h300000, 24'h280000, 24'h380000, 24'h2d0000,
		24'h3d0000, 24'h2f0000, 24'h3f0000, 24'h400000, 24'h500000, 24'h420000, 24'h520000,
		24'h440000, 24'h540000, 24'h498000, 24'h598000, 24'h4a0000, 24'h5a0000, 24'h4a8000,
		24'h5a8000, 24'h4b0000, 24'h5b0000, 24'h4b8000, 24'h5b8000, 24'h4c0000, 24'h5c0000,
		24'h4c8000, 24'h5c8000, 24'h4d0000, 24'h5d0000, 24'h458000, 24'h558000, 24'h460000,
		24'h560000, 24'h468000, 24'h568000, 24'h470000, 24'h570000, 24'h478000, 24'h578000,
		24'h480000, 24'h580000, 24'h488000, 24'h588000, 24'h490000, 24'h590000, 24'h5d0000,
		24'h5d8000, 24'h5e0000, 24'h5e8000, 24'h5f0000, 24'h5f8000, 24'h600000};
	localparam logic [OFFSET_W-1:0] BASE_V2 [56] = '{
		24'h000000, 24'h100000, 24'h200000, 24'h300000, 24'h280000, 24'h380000, 24'h2d0000,
		24'h3d0000, 24'h2c8000, 24'h3c8000, 24'h400000, 24'h500000, 24'h420000, 24'h520000,
		24'h440000, 24'h540000, 24'h598000, 24'h698000, 24'h5a0000, 24'h6a0000, 24'h5a8000,
		24'h6a8000, 24'h5b0000, 24'h6b0000, 24'h5b8000, 24'h6b8000, 24'h5c0000, 24'h6c0000,
		24'h5c8000, 24'h6c8000, 24'h5d0000, 24'h6d0000, 24'h458000, 24'h558000, 24'h460000,
		24'h560000, 24'h468000, 24'h568000, 24'h470000, 24'h570000, 24'h478000, 24'h578000,
		24'h480000, 24'h580000, 24'h488000, 24'h588000, 24'h490000, 24'h590000, 24'h5d8000,
		24'h6d8000, 24'h5e0000, 24'h6e0000, 24'h5e8000, 24'h6e8000, 24'h6e8000, 24'h000000};
	localparam logic [OFFSET_W-1:0] BASE_V3 [49] = '{
		24'h000000, 24'h020000, 24'h040000, 24'h060000, 24'h070000, 24'h090000, 24'h0b0000,
		24'h0d0000, 24'h0e0000, 24'h0f0000, 24'h120000, 24'h130000, 24'h140000, 24'h150000,
		24'h180000, 24'h190000, 24'h1a0000, 24'h1b0000, 24'h1e0000, 24'h1f0000, 24'h200000,
		24'h210000, 24'h240000, 24'h250000, 24'h260000, 24'h270000, 24'h2a0000, 24'h2b0000,
		24'h2c0000, 24'h2d0000, 24'h300000, 24'h310000, 24'h320000, 24'h330000, 24'h360000,
		24'h370000, 24'h380000, 24'h390000, 24'h3c0000, 24'h3d0000, 24'h400000, 24'h410000,
		24'h440000, 24'h450000, 24'h460000, 24'h470000, 24'h4a0000, 24'h4b0000, 24'h4c0000};
	localparam logic [OFFSET_W-1:0] BASE_V4 [36] = '{
		24'h000000, 24'h100000, 24'h200000, 24'h300000, 24'h3f7800, 24'h4f7800, 24'h3ff800,
		24'h4ff800, 24'h407800, 24'h507800, 24'h40f800, 24'h50f800, 24'h416800, 24'h516800,
		24'h41d800, 24'h51d800, 24'h424000, 24'h524000, 24'h523800, 24'h623800, 24'h526000,
		24'h626000, 24'h528000, 24'h628000, 24'h52a000, 24'h62a000, 24'h52b800, 24'h62b800,
		24'h52d000, 24'h62d000, 24'h52e800, 24'h62e800, 24'h618000, 24'h619000, 24'h61a000,
		24'h61a800};

	// Addresses that the random stimulus favors: the ID word and every port of every variant.
	localparam logic [ADDR_W-1:0] HOT_ADDRS [10] = '{
		24'h2fe446, 24'h2ffff8, 24'h2ffffa, 24'h2ffff0, 24'h2fffcc,
		24'h2fffc0, 24'h2fffe4, 24'h2fffd8, 24'h2fffda, 24'h2fffec};

	typedef struct {
		logic [ACTION_W-1:0] action;
		logic [ADDR_W-1:0]   address;
		logic [DATA_W-1:0]   data;
	} bus_access_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	spbr_access_if access_bus ();
	spbr_result_if result_bus ();

	sma_protection_bank_and_random_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.access    (access_bus),
		.result    (result_bus)
	);

	// Predictor copy of the configuration and the generator.
	logic [VARIANT_W-1:0] variant_sel;
	logic [DATA_W-1:0]    lfsr_word;

	bus_access_t  bus_accesses [$];
	spbr_result_t pending_responses [$];

	logic access_taken;
	logic receiver_hold;
	int   sender_idle_pct;
	int   receiver_stall_pct;
	int   mismatch_count;
	int   cycle_count;
	event start_hold_off;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Works out the device's answer to one bus access and steps the generator on a port read.
	function automatic spbr_result_t protection_response(
		input logic [ACTION_W-1:0] act,
		input logic [ADDR_W-1:0]   addr,
		input logic [DATA_W-1:0]   wdata
	);
		spbr_result_t r;
		logic [ADDR_W-1:0] a;
		logic [DATA_W-1:0] d;
		logic [5:0] idx;
		r = '0;
		a = addr;
		d = wdata;
		idx = '0;
		if (act == ACT_READ16) begin
			if (a == FIXED_ID_ADDR) begin
				r.read_data = FIXED_ID_WORD;
				r.read_answered = 1'b1;
			end else if (variant_sel <= VAR_TBL4 && variant_sel != VAR_TBL3 &&
					(a == RNG_PORT_A[variant_sel] || a == RNG_PORT_B[variant_sel])) begin
				r.read_data = lfsr_word;
				r.read_answered = 1'b1;
				lfsr_word = {lfsr_word[DATA_W-2:0], ^(lfsr_word & LFSR_TAPS)};
			end
		end else if (act == ACT_WRITE16 || act == ACT_WRITE8) begin
			// A byte write lands in one lane of the word and is compared at the even address.
			if (act == ACT_WRITE8) begin
				d = a[0] ? {8'h00, wdata[7:0]} : {wdata[7:0], 8'h00};
				a[0] = 1'b0;
			end
			if (variant_sel <= VAR_TBL4 && a == BANK_PORT[variant_sel]) begin
				for (int i = 0; i < 6; i++)
					idx[i] = d[BANK_BIT_SEL[variant_sel][i]];
				r.bank_valid = 1'b1;
				case (variant_sel)
					VAR_TBL0: if (idx < $size(BASE_V0)) r.bank_offset = BASE_V0[idx];
					VAR_TBL1: if (idx < $size(BASE_V1)) r.bank_offset = BASE_V1[idx];
					VAR_TBL2: if (idx < $size(BASE_V2)) r.bank_offset = BASE_V2[idx];
					VAR_TBL3: if (idx < $size(BASE_V3)) r.bank_offset = BASE_V3[idx];
					default:  if (idx < $size(BASE_V4)) r.bank_offset = BASE_V4[idx];
				endcase
			end else begin
				r.write_passed = 1'b1;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (mismatch_count < MAX_REPORTS)
			$display("MISMATCH at cycle %0d: %s got 0x%0h expected 0x%0h",
				cycle_count, what, got, want);
		mismatch_count++;
	endtask

	task automatic push_access(input logic [ACTION_W-1:0] act, input logic [ADDR_W-1:0] addr,
		input logic [DATA_W-1:0] wdata);
		bus_access_t item;
		item.action = act;
		item.address = addr;
		item.data = wdata;
		bus_accesses.push_back(item);
	endtask

	// Blocks until every access has been offered, taken and answered.
	task automatic wait_drained();
		while (bus_accesses.size() != 0 || access_bus.valid || pending_responses.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_VARIANT) begin
			variant_sel = value[VARIANT_W-1:0];
		end else begin
			lfsr_word = value;
		end
	endtask

	// One phase of random accesses under a fresh configuration and idling mix.
	task automatic run_phase(input logic [CFG_DATA_W-1:0] variant_word,
		input logic [CFG_DATA_W-1:0] seed_word, input bit load_seed, input int send_idle,
		input int recv_stall, input bit hold_receiver, input int count);
		logic [ACTION_W-1:0] act;
		logic [ADDR_W-1:0]   addr;
		logic [DATA_W-1:0]   wdata;
		int roll;
		wait_drained();
		write_register(REG_VARIANT, variant_word);
		if (load_seed)
			write_register(REG_SEED, seed_word);
		sender_idle_pct = send_idle;
		receiver_stall_pct = recv_stall;
		if (hold_receiver)
			-> start_hold_off;
		repeat (count) begin
			roll = int'($urandom_range(99));
			if (roll < 35)
				act = ACT_READ16;
			else if (roll < 65)
				act = ACT_WRITE16;
			else if (roll < 92)
				act = ACT_WRITE8;
			else
				act = ACT_NONE;
			// Mostly the interesting addresses, sometimes with the low bit flipped.
			if ($urandom_range(99) < 70) begin
				addr = HOT_ADDRS[4'($urandom_range(9))];
				if ($urandom_range(3) == 0)
					addr[0] = ~addr[0];
			end else begin
				addr = ADDR_W'($urandom());
			end
			roll = int'($urandom_range(19));
			if (roll == 0)
				wdata = '0;
			else if (roll == 1)
				wdata = '1;
			else
				wdata = DATA_W'($urandom());
			push_access(act, addr, wdata);
		end
	endtask

	// Offers the next queued access at the falling edge, holding an untaken one in place.
	always @(negedge clk) begin : drive_access
		bus_access_t item;
		if (access_bus.valid && !access_taken) begin
			// Still waiting for the current transfer.
		end else if (bus_accesses.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
			item = bus_accesses.pop_front();
			access_bus.valid <= 1'b1;
			access_bus.action <= item.action;
			access_bus.address <= item.address;
			access_bus.data <= item.data;
		end else begin
			access_bus.valid <= 1'b0;
		end
	end

	// Result side back-pressure, random or held low for a long stretch.
	always @(negedge clk) begin
		if (receiver_hold)
			result_bus.ready <= 1'b0;
		else
			result_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// Long receiver hold-off so that the block fills and stalls its input.
	initial begin
		forever begin
			@(start_hold_off);
			receiver_hold <= 1'b1;
			repeat (HOLD_OFF_CYCLES) @(negedge clk);
			receiver_hold <= 1'b0;
		end
	end

	// Checks each result transfer against the oldest prediction, then records new accesses.
	always @(posedge clk) begin : check_results
		spbr_result_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("sma_protection_bank_and_random_core_tb NOT OK");
			$finish;
		end else begin
			access_taken <= access_bus.valid && access_bus.ready;
			if (arst_n && result_bus.valid && result_bus.ready) begin
				if (pending_responses.size() == 0) begin
					report_mismatch("result with nothing outstanding, read_data",
						32'(result_bus.read_data), 32'd0);
				end else begin
					want = pending_responses.pop_front();
					if (result_bus.read_data !== want.read_data)
						report_mismatch("read_data", 32'(result_bus.read_data),
							32'(want.read_data));
					if (result_bus.read_answered !== want.read_answered)
						report_mismatch("read_answered", 32'(result_bus.read_answered),
							32'(want.read_answered));
					if (result_bus.bank_valid !== want.bank_valid)
						report_mismatch("bank_valid", 32'(result_bus.bank_valid),
							32'(want.bank_valid));
					if (result_bus.bank_offset !== want.bank_offset)
						report_mismatch("bank_offset", 32'(result_bus.bank_offset),
							32'(want.bank_offset));
					if (result_bus.write_passed !== want.write_passed)
						report_mismatch("write_passed", 32'(result_bus.write_passed),
							32'(want.write_passed));
				end
			end
			if (arst_n && access_bus.valid && access_bus.ready)
				pending_responses.push_back(protection_response(access_bus.action,
					access_bus.address, access_bus.data));
		end
	end

	// Reset, directed accesses, then random phases over several configurations.
	initial begin : stimulus
		logic [VARIANT_W-1:0] v;
		int mode;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		access_bus.valid = 1'b0;
		access_bus.action = ACT_NONE;
		access_bus.address = '0;
		access_bus.data = '0;
		result_bus.ready = 1'b0;
		access_taken = 1'b0;
		receiver_hold = 1'b0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		mismatch_count = 0;
		cycle_count = 0;
		variant_sel = VAR_TBL0;
		lfsr_word = SEED_AT_RESET;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Reset configuration: ID word, both generator ports, bank port in every write form.
		push_access(ACT_READ16, FIXED_ID_ADDR, 16'h0000);
		push_access(ACT_READ16, 24'h2ffff8, 16'h0000);
		push_access(ACT_READ16, 24'h2ffffa, 16'hffff);
		push_access(ACT_READ16, 24'h2ffff8, 16'h0000);
		push_access(ACT_READ16, 24'h000000, 16'h0000);
		push_access(ACT_READ16, 24'hffffff, 16'hffff);
		push_access(ACT_WRITE16, 24'h2ffff0, 16'h0000);
		// All data bits set gives an index past the end of the table.
		push_access(ACT_WRITE16, 24'h2ffff0, 16'hffff);
		// A word write at the odd neighbor of the bank port misses it.
		push_access(ACT_WRITE16, 24'h2ffff1, 16'hffff);
		push_access(ACT_WRITE8, 24'h2ffff0, 16'h00ff);
		push_access(ACT_WRITE8, 24'h2ffff1, 16'h00ff);
		push_access(ACT_WRITE8, 24'h2ffff1, 16'hff00);
		push_access(ACT_WRITE16, 24'hffffff, 16'h0000);
		push_access(ACT_NONE, FIXED_ID_ADDR, 16'hffff);
		push_access(ACT_WRITE16, FIXED_ID_ADDR, 16'h1234);
		push_access(ACT_READ16, 24'h2fe447, 16'h0000);
		wait_drained();

		// Variant without a generator still answers the ID word.
		write_register(REG_VARIANT, CFG_DATA_W'(VAR_TBL3));
		push_access(ACT_READ16, FIXED_ID_ADDR, 16'h0000);
		push_access(ACT_READ16, 24'h2ffff8, 16'h0000);
		push_access(ACT_WRITE16, 24'h2fffe4, 16'hffff);
		wait_drained();

		// Code seven has no ports at all; upper data bits of the write are ignored.
		write_register(REG_VARIANT, 16'hffff);
		push_access(ACT_READ16, FIXED_ID_ADDR, 16'h0000);
		push_access(ACT_READ16, 24'h2ffff8, 16'h0000);
		push_access(ACT_WRITE16, 24'h2ffff0, 16'habcd);
		push_access(ACT_WRITE8, 24'h2ffff1, 16'h0012);

		// Random phases across the idling mixes and register extremes.
		run_phase(CFG_DATA_W'(VAR_TBL1), 16'hffff, 1'b1, 0, 0, 1'b0, 100);
		run_phase(CFG_DATA_W'(VAR_TBL2), CFG_DATA_W'($urandom()), 1'b1, 48, 0, 1'b0, 100);
		run_phase(CFG_DATA_W'(VAR_TBL4), 16'h0000, 1'b1, 0, 48, 1'b0, 100);
		run_phase(CFG_DATA_W'(VAR_TBL3), 16'h0001, 1'b1, 16, 16, 1'b0, 100);
		run_phase(CFG_DATA_W'(VAR_TBL0), 16'h0000, 1'b0, 0, 0, 1'b1, 80);
		run_phase(16'h0005, 16'h0000, 1'b0, 16, 16, 1'b0, 30);
		run_phase(16'hfffe, CFG_DATA_W'($urandom()), 1'b1, 48, 48, 1'b0, 30);
		repeat (6) begin
			v = VARIANT_W'($urandom_range(7));
			mode = int'($urandom_range(3));
			run_phase((CFG_DATA_W'($urandom()) & 16'hfff8) | {13'd0, v},
				CFG_DATA_W'($urandom()), 1'($urandom_range(1)),
				(mode == 1) ? 48 : (mode == 3) ? 16 : 0,
				(mode == 2) ? 48 : (mode == 3) ? 16 : 0, 1'b0, 40);
		end

		wait_drained();
		repeat (5) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("sma_protection_bank_and_random_core_tb OK");
		end else begin
			$display("sma_protection_bank_and_random_core_tb NOT OK");
		end
		$finish;
	end

endmodule
